>>> rtl/cnma_pkg.sv
package cnma_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int GRAY_LEVELS_DEF = 16;
	localparam int GRAY_FIRST      = 2;

	localparam int RGB_W  = 24;
	localparam int DIST_W = 13;

	// Larger than any real distance (3 * 255), so the first entry scanned always replaces it.
	localparam logic [DIST_W-1:0] NO_MATCH_DIST = 13'd5000;

	localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] BLACK_RGB = 24'h000000;

	// Gray codes for the two fixed entries.
	localparam logic [RGB_W-1:0] GRAY_CODE_BLACK = 24'd0;
	localparam logic [RGB_W-1:0] GRAY_CODE_WHITE = 24'd1;

	// Register index, taken from paddr[2].
	localparam logic REG_GRAY_MODE = 1'b0;

	typedef struct packed {
		logic [7:0] req_red;
		logic [7:0] req_green;
		logic [7:0] req_blue;
	} req_t;

	typedef struct packed {
		logic [7:0]       entry_index;
		logic [RGB_W-1:0] colour_code;
		logic             code_changed;
		logic             newly_added;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = (a > b) ? (a - b) : (b - a);
		return r;
	endfunction

endpackage

>>> rtl/colormap_nearest_match_allocator.sv
// After a request is accepted, the palette is scanned from entry 0 up to the last entry
// in use or to an exact match; a finish state then drives the registered result strobe.
// Throughput: one request at a time; the palette memory is read one entry per cycle.
// busy drops in the cycle the result is shown, so the next request can follow at once.
// Reset: two entries in use (white at 0, black at 1), gray_mode 0, no previous code;
// the memory needs no clearing pass. The receiver cannot stall results.
module colormap_nearest_match_allocator #(
	parameter int TABLE_DEPTH = cnma_pkg::TABLE_DEPTH_DEF,
	parameter int GRAY_LEVELS = cnma_pkg::GRAY_LEVELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cnma_pkg::req_t    req,
	output logic              busy,
	output logic              done,
	output cnma_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int MW = $clog2(GRAY_LEVELS);
	localparam logic [IW-1:0] FULL_LVL = IW'(TABLE_DEPTH - 1);
	localparam logic [MW-1:0] MOD_LAST = MW'(GRAY_LEVELS - 2);

	cnma_pkg::state_t state_q, state_nx;

	logic                        gray_mode_q;
	logic [IW-1:0]               used_q;
	logic [cnma_pkg::RGB_W-1:0]  prev_code_q;
	logic                        prev_valid_q;

	cnma_pkg::req_t              req_q;
	logic [IW-1:0]               rd_idx_q;
	logic [MW-1:0]               mod_q;
	logic                        valid_s1;
	logic [IW-1:0]               idx_s1;
	logic [MW-1:0]               mod_s1;
	logic [IW-1:0]               best_q;
	logic [MW-1:0]               best_mod_q;
	logic [cnma_pkg::DIST_W-1:0] best_dist_q;
	logic                        exact_q;

	logic                        done_q;
	cnma_pkg::result_t           result_q;

	logic                        accept;
	logic                        issue;
	logic                        ram_we;
	logic [cnma_pkg::RGB_W-1:0]  req_rgb;
	logic [cnma_pkg::RGB_W-1:0]  rdata;
	logic [cnma_pkg::RGB_W-1:0]  entry_rgb;
	logic [9:0]                  dist_sum;
	logic                        hit;
	logic                        scan_end;
	logic                        add;
	logic [IW-1:0]               fin_best;
	logic [MW-1:0]               fin_mod;
	logic [cnma_pkg::RGB_W-1:0]  fin_code;
	logic                        fin_changed;
	logic                        cfg_we;

	assign accept  = start && !busy;
	assign req_rgb = {req_q.req_red, req_q.req_green, req_q.req_blue};

	cnma_ram #(
		.WIDTH(cnma_pkg::RGB_W),
		.DEPTH(TABLE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(used_q),
		.wdata(req_rgb),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	// Entries 0 and 1 are never written, so their fixed colors are supplied here.
	always_comb begin
		if (idx_s1 == IW'(0)) begin
			entry_rgb = cnma_pkg::WHITE_RGB;
		end else if (idx_s1 == IW'(1)) begin
			entry_rgb = cnma_pkg::BLACK_RGB;
		end else begin
			entry_rgb = rdata;
		end
	end

	assign dist_sum = 10'(cnma_pkg::abs_diff8(entry_rgb[23:16], req_q.req_red))
	                + 10'(cnma_pkg::abs_diff8(entry_rgb[15:8], req_q.req_green))
	                + 10'(cnma_pkg::abs_diff8(entry_rgb[7:0], req_q.req_blue));

	assign hit      = valid_s1 && (dist_sum == 10'd0);
	assign scan_end = (rd_idx_q == used_q) && !valid_s1;

	// After a scan with no exact match, mod_q holds used_q mod (GRAY_LEVELS-1).
	assign add      = !exact_q && (used_q < FULL_LVL);
	assign fin_best = add ? used_q : best_q;
	assign fin_mod  = add ? mod_q : best_mod_q;

	always_comb begin
		if (gray_mode_q) begin
			if (fin_best == IW'(1)) begin
				fin_code = cnma_pkg::GRAY_CODE_BLACK;
			end else if (fin_best == IW'(0)) begin
				fin_code = cnma_pkg::GRAY_CODE_WHITE;
			end else begin
				fin_code = cnma_pkg::RGB_W'(cnma_pkg::GRAY_FIRST) + cnma_pkg::RGB_W'(fin_mod);
			end
			fin_changed = 1'b0;
		end else begin
			fin_code    = req_rgb;
			fin_changed = !prev_valid_q || (req_rgb != prev_code_q);
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			cnma_pkg::ST_IDLE: begin
				if (accept) begin
					state_nx = cnma_pkg::ST_SCAN;
				end
			end
			cnma_pkg::ST_SCAN: begin
				if (hit || scan_end) begin
					state_nx = cnma_pkg::ST_FINISH;
				end
			end
			cnma_pkg::ST_FINISH: begin
				state_nx = cnma_pkg::ST_IDLE;
			end
			default: begin
				state_nx = cnma_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy   = 1'b1;
		issue  = 1'b0;
		ram_we = 1'b0;
		case (state_q)
			cnma_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			cnma_pkg::ST_SCAN: begin
				issue = (rd_idx_q != used_q) && !hit;
			end
			cnma_pkg::ST_FINISH: begin
				ram_we = add;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cnma_pkg::ST_IDLE;
			used_q       <= IW'(2);
			prev_code_q  <= '0;
			prev_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q  <= state_nx;
			valid_s1 <= issue;
			done_q   <= (state_q == cnma_pkg::ST_FINISH);
			if (state_q == cnma_pkg::ST_FINISH) begin
				prev_code_q  <= fin_code;
				prev_valid_q <= 1'b1;
				if (add) begin
					used_q <= used_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q       <= req;
			rd_idx_q    <= '0;
			mod_q       <= '0;
			best_q      <= '0;
			best_mod_q  <= '0;
			best_dist_q <= cnma_pkg::NO_MATCH_DIST;
			exact_q     <= 1'b0;
		end
		if (issue) begin
			rd_idx_q <= rd_idx_q + IW'(1);
			mod_q    <= (mod_q == MOD_LAST) ? '0 : mod_q + MW'(1);
		end
		idx_s1 <= rd_idx_q;
		mod_s1 <= mod_q;
		if (state_q == cnma_pkg::ST_SCAN && valid_s1) begin
			if (hit) begin
				exact_q    <= 1'b1;
				best_q     <= idx_s1;
				best_mod_q <= mod_s1;
			end else if (cnma_pkg::DIST_W'(dist_sum) < best_dist_q) begin
				best_dist_q <= cnma_pkg::DIST_W'(dist_sum);
				best_q      <= idx_s1;
				best_mod_q  <= mod_s1;
			end
		end
		if (state_q == cnma_pkg::ST_FINISH) begin
			result_q.entry_index  <= 8'(fin_best);
			result_q.colour_code  <= fin_code;
			result_q.code_changed <= fin_changed;
			result_q.newly_added  <= add;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_mode_q <= 1'b0;
		end else if (cfg_we && paddr[2] == cnma_pkg::REG_GRAY_MODE) begin
			gray_mode_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == cnma_pkg::REG_GRAY_MODE) ? {31'd0, gray_mode_q} : 32'd0;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held longer than one cycle");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy dropped without a result");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request did not start a scan");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q >= IW'(2)) && (used_q <= FULL_LVL)) else $error("entry count out of range");
`endif

endmodule

>>> rtl/cnma_ram.sv
module cnma_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> tb/tb_colormap_nearest_match_allocator.sv
module tb_colormap_nearest_match_allocator;
	import cnma_pkg::*;

	localparam int PAL_DEPTH = TABLE_DEPTH_DEF;
	localparam logic [2:0] ADDR_GRAY_MODE = {REG_GRAY_MODE, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED = {~REG_GRAY_MODE, 2'b00};
	localparam int DRAIN_CYCLES = PAL_DEPTH + 8;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Shadow palette and code history, updated in request order.
	logic [RGB_W-1:0] pal_rgb [PAL_DEPTH];
	int unsigned pal_count;
	logic [RGB_W-1:0] last_code;
	bit last_code_valid;
	bit gray_sel;

	result_t expected_results[$];
	req_t last_req;
	int unsigned idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	always #2 clk = ~clk;

	colormap_nearest_match_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic int unsigned channel_gap(logic [7:0] a, logic [7:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic result_t predict_allocation(req_t r);
		int unsigned best;
		int unsigned best_sum;
		int unsigned diff_sum;
		int unsigned idx;
		bit exact;
		logic [RGB_W-1:0] rgb;
		logic [RGB_W-1:0] code;
		result_t res;
		rgb = {r.req_red, r.req_green, r.req_blue};
		best = 0;
		best_sum = NO_MATCH_DIST;
		exact = 1'b0;
		for (idx = 0; idx < pal_count; idx++) begin
			diff_sum = channel_gap(pal_rgb[idx][23:16], r.req_red)
				+ channel_gap(pal_rgb[idx][15:8], r.req_green)
				+ channel_gap(pal_rgb[idx][7:0], r.req_blue);
			if (diff_sum == 0) begin
				best = idx;
				exact = 1'b1;
				break;
			end
			// Strict compare keeps the lowest index on a tie.
			if (diff_sum < best_sum) begin
				best_sum = diff_sum;
				best = idx;
			end
		end
		res.newly_added = 1'b0;
		if (!exact && pal_count < PAL_DEPTH - 1) begin
			pal_rgb[pal_count] = rgb;
			best = pal_count;
			pal_count++;
			res.newly_added = 1'b1;
		end
		if (gray_sel) begin
			if (best == 1)
				code = GRAY_CODE_BLACK;
			else if (best == 0)
				code = GRAY_CODE_WHITE;
			else
				code = RGB_W'(GRAY_FIRST + best % (GRAY_LEVELS_DEF - 1));
			res.code_changed = 1'b0;
		end else begin
			code = rgb;
			res.code_changed = !last_code_valid || code != last_code;
		end
		last_code = code;
		last_code_valid = 1'b1;
		res.entry_index = 8'(best);
		res.colour_code = code;
		return res;
	endfunction

	function automatic logic [7:0] nudge(logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// Mostly repeats and near neighbours of known colours, so the scan runs
	// into exact hits, close calls and ties once the palette is full.
	function automatic req_t next_request();
		int unsigned pick;
		logic [RGB_W-1:0] base;
		req_t r;
		pick = $urandom_range(0, 99);
		base = pal_rgb[$urandom_range(0, pal_count - 1)];
		if (pick < 40) begin
			r = base;
		end else if (pick < 65) begin
			r.req_red = nudge(base[23:16]);
			r.req_green = nudge(base[15:8]);
			r.req_blue = nudge(base[7:0]);
		end else if (pick < 75) begin
			r = last_req;
		end else begin
			r = 24'($urandom);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_request(req_t r);
		int unsigned gap;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_allocation(r));
		last_req = r;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait on the falling edge so the checker has already retired the last result.
	task automatic settle_pipeline();
		start <= 1'b0;
		do @(negedge clk); while (expected_results.size() != 0 || busy);
		@(posedge clk);
	endtask

	task automatic config_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_GRAY_MODE)
			gray_sel = data[0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_fixed_entries();
		idle_pct = 25;
		send_request(req_t'(24'hFFFFFF));
		send_request(req_t'(24'h000000));
		send_request(req_t'(24'h000000));
		send_request(req_t'(24'hFF0000));
		send_request(req_t'(24'h00FF00));
		send_request(req_t'(24'h0000FF));
		send_request(req_t'(24'h7F7F7F));
		send_request(req_t'(24'h808080));
		send_request(req_t'(24'hFF0000));
		send_request(req_t'(24'h010000));
	endtask

	task automatic test_gray_codes();
		settle_pipeline();
		config_write(ADDR_GRAY_MODE, 32'd1);
		send_request(req_t'(24'hFFFFFF));
		send_request(req_t'(24'h000000));
		send_request(req_t'(24'hFF0000));
		send_request(req_t'(24'h123456));
		send_request(req_t'(24'hAA55AA));
	endtask

	task automatic test_register_decode();
		// A write outside the register map must leave gray mode on.
		settle_pipeline();
		config_write(ADDR_UNMAPPED, 32'd0);
		send_request(req_t'(24'hFFFFFF));
		// Only bit 0 counts; the packed code then equals the last gray code.
		settle_pipeline();
		config_write(ADDR_GRAY_MODE, 32'hFFFF_FFFE);
		send_request(req_t'(24'h000001));
	endtask

	task automatic test_random_requests(bit gray, int unsigned hold_pct, int unsigned count);
		settle_pipeline();
		config_write(ADDR_GRAY_MODE, {31'd0, gray});
		idle_pct = hold_pct;
		repeat (count)
			send_request(next_request());
	endtask

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request outstanding", 32'(result), 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (result.entry_index !== want.entry_index)
					report_mismatch("entry_index", 32'(result.entry_index), 32'(want.entry_index));
				if (result.colour_code !== want.colour_code)
					report_mismatch("colour_code", 32'(result.colour_code), 32'(want.colour_code));
				if (result.code_changed !== want.code_changed)
					report_mismatch("code_changed", 32'(result.code_changed), 32'(want.code_changed));
				if (result.newly_added !== want.newly_added)
					report_mismatch("newly_added", 32'(result.newly_added), 32'(want.newly_added));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < PAL_DEPTH; i++)
			pal_rgb[i] = '0;
		pal_rgb[0] = WHITE_RGB;
		pal_rgb[1] = BLACK_RGB;
		pal_count = 2;
		last_code = '0;
		last_code_valid = 1'b0;
		gray_sel = 1'b0;
		last_req = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_entries();
		test_gray_codes();
		test_register_decode();
		test_random_requests(1'b0, 38, 400);
		test_random_requests(1'b1, 58, 400);
		test_random_requests(1'b0, 0, 332);

		settle_pipeline();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> colormap_nearest_match_allocator.f
rtl/cnma_pkg.sv
rtl/cnma_ram.sv
rtl/colormap_nearest_match_allocator.sv
tb/tb_colormap_nearest_match_allocator.sv
